/* rtl/zmwl_pkg.sv */
package zmwl_pkg;

  localparam int LABEL_W = 10;
  localparam int AREA_W = 32;
  localparam int COORD_W = 16;

  localparam int LABEL_COUNT_DEF = 1024;
  localparam int AREA_BITS_DEF = 32;
  localparam int COORD_BITS_DEF = 16;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_READ,
    ST_UPD_WRITE,
    ST_SCAN_READ,
    ST_SCAN_CHECK
  } state_e;

  typedef struct packed {
    logic load;
    logic clr_write;
    logic upd_read;
    logic upd_write;
    logic scan_read;
    logic scan_check;
  } cmd_t;

  typedef struct packed {
    logic in_read;
    logic in_skip;
    logic last;
    logic hit;
  } status_t;

endpackage

/* rtl/zonal_max_with_location.sv */
// Zonal maximum with location: per-label largest area and the cell that holds it.
// A request is taken on a rising edge where start_i is high and busy_o is low.
// With mode_i low the request is a pixel update; it keeps busy_o high through
// ST_UPD_READ and ST_UPD_WRITE (read, compare and write of one memory entry), and
// a nodata or out-of-range pixel is dropped without raising busy_o.
// With mode_i high the request reads out the next found label at or above the
// read pointer and clears it. The scan reads each entry in ST_SCAN_READ and checks
// it in ST_SCAN_CHECK; done_o is registered from the final check and rises for one
// cycle at the same edge where busy_o falls.
// A pixel update produces no result. done_o is registered and high for exactly
// one cycle; the registered result fields hold until the next readout, and the
// receiver cannot stall either. When no found entry remains at or above the
// pointer, valid_res_o is low, the other fields are zero and the pointer returns
// to label 0. After reset the block sweeps its label memory to clear every entry,
// one entry per cycle, with busy_o held high.
module zonal_max_with_location import zmwl_pkg::*; #(
  parameter int LABEL_COUNT = LABEL_COUNT_DEF,
  parameter int AREA_BITS = AREA_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic [LABEL_W-1:0] label_i,
  input  logic [AREA_W-1:0]  area_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic               nodata_i,
  output logic               done_o,
  output logic               valid_res_o,
  output logic [LABEL_W-1:0] out_label_o,
  output logic [AREA_W-1:0]  max_area_o,
  output logic [COORD_W-1:0] max_col_o,
  output logic [COORD_W-1:0] max_row_o
);

  cmd_t    cmd;
  status_t status;

  zmwl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  zmwl_dp #(
    .LABEL_COUNT (LABEL_COUNT),
    .AREA_BITS   (AREA_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .mode_i      (mode_i),
    .label_i     (label_i),
    .area_i      (area_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .nodata_i    (nodata_i),
    .done_o      (done_o),
    .valid_res_o (valid_res_o),
    .out_label_o (out_label_o),
    .max_area_o  (max_area_o),
    .max_col_o   (max_col_o),
    .max_row_o   (max_row_o)
  );

endmodule

/* rtl/zmwl_ctrl.sv */
module zmwl_ctrl import zmwl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (status_i.in_read) begin
            state_d = ST_SCAN_READ;
          end else if (!status_i.in_skip) begin
            state_d = ST_UPD_READ;
          end
        end
      end
      ST_UPD_READ: state_d = ST_UPD_WRITE;
      ST_UPD_WRITE: state_d = ST_IDLE;
      ST_SCAN_READ: state_d = ST_SCAN_CHECK;
      ST_SCAN_CHECK: begin
        if (status_i.hit || status_i.last) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN_READ;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_CLEAR: cmd_o.clr_write = 1'b1;
      ST_IDLE: begin
        busy_o = 1'b0;
        cmd_o.load = start_i;
      end
      ST_UPD_READ: cmd_o.upd_read = 1'b1;
      ST_UPD_WRITE: cmd_o.upd_write = 1'b1;
      ST_SCAN_READ: cmd_o.scan_read = 1'b1;
      ST_SCAN_CHECK: cmd_o.scan_check = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* rtl/zmwl_dp.sv */
module zmwl_dp import zmwl_pkg::*; #(
  parameter int LABEL_COUNT = LABEL_COUNT_DEF,
  parameter int AREA_BITS = AREA_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               mode_i,
  input  logic [LABEL_W-1:0] label_i,
  input  logic [AREA_W-1:0]  area_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic               nodata_i,
  output logic               done_o,
  output logic               valid_res_o,
  output logic [LABEL_W-1:0] out_label_o,
  output logic [AREA_W-1:0]  max_area_o,
  output logic [COORD_W-1:0] max_col_o,
  output logic [COORD_W-1:0] max_row_o
);

  localparam int LW = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;
  localparam logic [LW-1:0] LAST_IDX = LW'(LABEL_COUNT - 1);

  logic                  mem_found [LABEL_COUNT];
  logic [AREA_BITS-1:0]  mem_area [LABEL_COUNT];
  logic [COORD_BITS-1:0] mem_col [LABEL_COUNT];
  logic [COORD_BITS-1:0] mem_row [LABEL_COUNT];

  logic [LW-1:0]         ptr_q, ptr_d;
  logic [LW-1:0]         lbl_q;
  logic [AREA_BITS-1:0]  area_q;
  logic [COORD_BITS-1:0] col_q, row_q;

  logic                  rd_found_q;
  logic [AREA_BITS-1:0]  rd_area_q;
  logic [COORD_BITS-1:0] rd_col_q, rd_row_q;
  logic [LW-1:0]         rd_addr;

  logic                  we;
  logic [LW-1:0]         wr_addr;
  logic                  wr_found;
  logic [AREA_BITS-1:0]  wr_area;
  logic [COORD_BITS-1:0] wr_col, wr_row;

  logic                  done_q, done_d;
  logic                  res_load;
  logic                  valid_res_q;
  logic [LABEL_W-1:0]    out_label_q;
  logic [AREA_W-1:0]     max_area_q;
  logic [COORD_W-1:0]    max_col_q, max_row_q;

  assign status_o.in_read = (mode_i == MODE_READ);
  assign status_o.in_skip = nodata_i || (32'(label_i) >= LABEL_COUNT);
  assign status_o.last = (ptr_q == LAST_IDX);
  assign status_o.hit = rd_found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lbl_q <= LW'(label_i);
      area_q <= AREA_BITS'(area_i);
      col_q <= COORD_BITS'(col_i);
      row_q <= COORD_BITS'(row_i);
    end
  end

  assign rd_addr = cmd_i.scan_read ? ptr_q : lbl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_read || cmd_i.scan_read) begin
      rd_found_q <= mem_found[rd_addr];
      rd_area_q <= mem_area[rd_addr];
      rd_col_q <= mem_col[rd_addr];
      rd_row_q <= mem_row[rd_addr];
    end
  end

  always_comb begin
    we = 1'b0;
    wr_addr = ptr_q;
    wr_found = 1'b0;
    wr_area = rd_area_q;
    wr_col = rd_col_q;
    wr_row = rd_row_q;
    if (cmd_i.clr_write) begin
      we = 1'b1;
      wr_area = '0;
      wr_col = '0;
      wr_row = '0;
    end else if (cmd_i.upd_write) begin
      we = !rd_found_q || (area_q > rd_area_q);
      wr_addr = lbl_q;
      wr_found = 1'b1;
      wr_area = area_q;
      wr_col = col_q;
      wr_row = row_q;
    end else if (cmd_i.scan_check) begin
      we = rd_found_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_found[wr_addr] <= wr_found;
      mem_area[wr_addr] <= wr_area;
      mem_col[wr_addr] <= wr_col;
      mem_row[wr_addr] <= wr_row;
    end
  end

  // The pointer doubles as the sweep counter after reset and as the scan position.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.clr_write || cmd_i.scan_check) begin
      ptr_d = status_o.last ? '0 : ptr_q + LW'(1);
    end
  end

  assign res_load = cmd_i.scan_check && (rd_found_q || status_o.last);
  assign done_d = res_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      done_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      valid_res_q <= rd_found_q;
      out_label_q <= rd_found_q ? LABEL_W'(ptr_q) : '0;
      max_area_q <= rd_found_q ? AREA_W'(rd_area_q) : '0;
      max_col_q <= rd_found_q ? COORD_W'(rd_col_q) : '0;
      max_row_q <= rd_found_q ? COORD_W'(rd_row_q) : '0;
    end
  end

  assign done_o = done_q;
  assign valid_res_o = valid_res_q;
  assign out_label_o = out_label_q;
  assign max_area_o = max_area_q;
  assign max_col_o = max_col_q;
  assign max_row_o = max_row_q;

endmodule

/* tb/sv/zonal_max_with_location_checker.sv */
`timescale 1ns / 1ps

module zonal_max_with_location_checker import zmwl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               mode_i,
  input  logic [LABEL_W-1:0] label_i,
  input  logic [AREA_W-1:0]  area_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic               nodata_i,
  input  logic               done_i,
  input  logic               valid_res_i,
  input  logic [LABEL_W-1:0] out_label_i,
  input  logic [AREA_W-1:0]  max_area_i,
  input  logic [COORD_W-1:0] max_col_i,
  input  logic [COORD_W-1:0] max_row_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 entries_o,
  output int                 empties_o
);

  typedef struct packed {
    logic               valid;
    logic [LABEL_W-1:0] label;
    logic [AREA_W-1:0]  area;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } zone_peak_t;

  logic               peak_found [LABEL_COUNT_DEF];
  logic [AREA_W-1:0]  peak_area [LABEL_COUNT_DEF];
  logic [COORD_W-1:0] peak_col [LABEL_COUNT_DEF];
  logic [COORD_W-1:0] peak_row [LABEL_COUNT_DEF];
  int                 scan_ptr;
  zone_peak_t         peak_q [$];

  // Returns the next found label at or above the scan pointer and clears it.
  function automatic zone_peak_t take_next_peak();
    zone_peak_t r;
    int k;
    r = '0;
    k = scan_ptr;
    while (k < LABEL_COUNT_DEF && !peak_found[k]) begin
      k++;
    end
    if (k < LABEL_COUNT_DEF) begin
      r.valid = 1'b1;
      r.label = k[LABEL_W-1:0];
      r.area = peak_area[k];
      r.col = peak_col[k];
      r.row = peak_row[k];
      peak_found[k] = 1'b0;
      scan_ptr = (k + 1 >= LABEL_COUNT_DEF) ? 0 : k + 1;
    end else begin
      scan_ptr = 0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    zone_peak_t want;
    if (!rst_ni) begin
      for (int k = 0; k < LABEL_COUNT_DEF; k++) begin
        peak_found[k] = 1'b0;
      end
      scan_ptr = 0;
      peak_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      entries_o = 0;
      empties_o = 0;
    end else begin
      if (done_i) begin
        if (peak_q.size() == 0) begin
          $display("%0t: result with no readout pending, expected none, actual label %0h",
                   $time, out_label_i);
          fail_count_o++;
        end else begin
          want = peak_q.pop_front();
          check_field("valid_res", 64'(want.valid), 64'(valid_res_i));
          check_field("out_label", 64'(want.label), 64'(out_label_i));
          check_field("max_area", 64'(want.area), 64'(max_area_i));
          check_field("max_col", 64'(want.col), 64'(max_col_i));
          check_field("max_row", 64'(want.row), 64'(max_row_i));
        end
        if (valid_res_i) begin
          entries_o++;
        end else begin
          empties_o++;
        end
      end
      if (start_i && !busy_i) begin
        if (mode_i == MODE_READ) begin
          peak_q.push_back(take_next_peak());
        end else if (!nodata_i && int'(label_i) < LABEL_COUNT_DEF &&
                     (!peak_found[label_i] || area_i > peak_area[label_i])) begin
          peak_found[label_i] = 1'b1;
          peak_area[label_i] = area_i;
          peak_col[label_i] = col_i;
          peak_row[label_i] = row_i;
        end
      end
      pending_o = peak_q.size();
    end
  end

endmodule

/* tb/sv/zonal_max_with_location_tb.sv */
`timescale 1ns / 1ps

module zonal_max_with_location_tb;
  import zmwl_pkg::*;

  localparam int ITEM_TARGET = 1380;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               mode;
  logic [LABEL_W-1:0] label;
  logic [AREA_W-1:0]  area;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic               nodata;
  logic               done;
  logic               valid_res;
  logic [LABEL_W-1:0] out_label;
  logic [AREA_W-1:0]  max_area;
  logic [COORD_W-1:0] max_col;
  logic [COORD_W-1:0] max_row;
  int                 fail_count;
  int                 pending;
  int                 entries;
  int                 empties;

  int updates;
  int skipped;
  int readouts;
  int burst_left;
  int zone_pool [$];

  zonal_max_with_location uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .mode_i      (mode),
    .label_i     (label),
    .area_i      (area),
    .col_i       (col),
    .row_i       (row),
    .nodata_i    (nodata),
    .done_o      (done),
    .valid_res_o (valid_res),
    .out_label_o (out_label),
    .max_area_o  (max_area),
    .max_col_o   (max_col),
    .max_row_o   (max_row)
  );

  zonal_max_with_location_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .mode_i       (mode),
    .label_i      (label),
    .area_i       (area),
    .col_i        (col),
    .row_i        (row),
    .nodata_i     (nodata),
    .done_i       (done),
    .valid_res_i  (valid_res),
    .out_label_i  (out_label),
    .max_area_i   (max_area),
    .max_col_i    (max_col),
    .max_row_i    (max_row),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .entries_o    (entries),
    .empties_o    (empties)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic idle_for(input int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Holds the request on the ports until the block takes it.
  task automatic put_request(input logic m, input logic [LABEL_W-1:0] lab,
                             input logic [AREA_W-1:0] ar, input logic [COORD_W-1:0] c,
                             input logic [COORD_W-1:0] r, input logic skip);
    @(negedge clk);
    start = 1'b1;
    mode = m;
    label = lab;
    area = ar;
    col = c;
    row = r;
    nodata = skip;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (m == MODE_READ) begin
      readouts++;
    end else if (skip) begin
      skipped++;
    end else begin
      updates++;
    end
  endtask

  task automatic send(input logic m, input logic [LABEL_W-1:0] lab,
                      input logic [AREA_W-1:0] ar, input logic [COORD_W-1:0] c,
                      input logic [COORD_W-1:0] r, input logic skip);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 6));
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
    end
    burst_left--;
    put_request(m, lab, ar, c, r, skip);
  endtask

  task automatic ask_readout();
    send(MODE_READ, LABEL_W'($urandom), $urandom, COORD_W'($urandom),
         COORD_W'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_pixel();
    logic [AREA_W-1:0] ar;
    case ($urandom_range(0, 9))
      0:       ar = '0;
      1:       ar = '1;
      2, 3, 4: ar = $urandom_range(0, 7);
      5, 6:    ar = $urandom_range(0, 1000);
      default: ar = $urandom;
    endcase
    send(MODE_UPDATE, LABEL_W'(zone_pool[$urandom_range(0, zone_pool.size() - 1)]), ar,
         COORD_W'($urandom), COORD_W'($urandom), $urandom_range(0, 9) == 0);
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    start = 1'b0;
    mode = MODE_UPDATE;
    label = '0;
    area = '0;
    col = '0;
    row = '0;
    nodata = 1'b0;
    updates = 0;
    skipped = 0;
    readouts = 0;
    burst_left = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty store, field extremes, ties, nodata, pointer wrap and
    // labels found below the read pointer.
    ask_readout();
    send(MODE_UPDATE, 10'd0, 32'h0000_0000, 16'h0000, 16'h0000, 1'b0);
    send(MODE_UPDATE, 10'd1023, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send(MODE_UPDATE, 10'd0, 32'h0000_0000, 16'h0005, 16'h0005, 1'b0);
    send(MODE_UPDATE, 10'd1023, 32'h0000_0005, 16'h0001, 16'h0001, 1'b0);
    send(MODE_UPDATE, 10'd5, 32'hFFFF_FFFF, 16'h0009, 16'h0009, 1'b1);
    send(MODE_UPDATE, 10'd5, 32'h0000_0007, 16'h0001, 16'h0002, 1'b0);
    send(MODE_UPDATE, 10'd5, 32'h0000_0008, 16'h0003, 16'h0004, 1'b0);
    ask_readout();
    ask_readout();
    send(MODE_UPDATE, 10'd2, 32'h0000_0064, 16'h1234, 16'h4321, 1'b0);
    ask_readout();
    ask_readout();
    ask_readout();
    send(MODE_UPDATE, 10'd512, 32'h8000_0000, 16'hAAAA, 16'h5555, 1'b0);
    send(MODE_UPDATE, 10'd511, 32'h7FFF_FFFF, 16'h5555, 16'hAAAA, 1'b0);
    ask_readout();
    send(MODE_UPDATE, 10'd300, 32'h0000_0001, 16'h00FF, 16'hFF00, 1'b0);
    ask_readout();
    ask_readout();
    ask_readout();
    ask_readout();
    wait_drained();

    // Random phases: pixels on a small set of labels so that ties and
    // replacements occur, with stray readouts, then usually a full drain.
    while (updates + skipped + readouts < ITEM_TARGET) begin
      zone_pool.delete();
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) begin
          zone_pool.push_back($urandom_range(0, 1) ? LABEL_COUNT_DEF - 1 : 0);
        end else begin
          zone_pool.push_back($urandom_range(0, LABEL_COUNT_DEF - 1));
        end
      end
      repeat ($urandom_range(10, 60)) begin
        if ($urandom_range(0, 19) == 0) begin
          ask_readout();
        end else begin
          random_pixel();
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        repeat (zone_pool.size() + 2) ask_readout();
      end
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
    end

    @(negedge clk);
    start = 1'b0;
    n = 0;
    while (n < 10000 && (pending != 0 || busy)) begin
      @(negedge clk);
      n++;
    end
    repeat (20) @(negedge clk);
    if (pending != 0) begin
      $display("%0t: %0d readout results never arrived", $time, pending);
    end
    $display("Run covered %0d pixel updates, %0d nodata pixels and %0d readouts.",
             updates, skipped, readouts);
    $display("Readouts returned %0d entries and %0d empty answers.", entries, empties);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* zonal_max_with_location.f */
rtl/zmwl_pkg.sv
rtl/zmwl_ctrl.sv
rtl/zmwl_dp.sv
rtl/zonal_max_with_location.sv
tb/sv/zonal_max_with_location_checker.sv
tb/sv/zonal_max_with_location_tb.sv
